[sv/psam_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psam_pkg: shared types for the per-axis point median block
// Coordinate type, result count width and the lane control group.
// ----------------------------------------------------------------------------
package psam_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned SizeW  = 9;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [SizeW-1:0]         size_t;

	typedef struct packed {
		logic start;
		logic rd_med;
	} lane_ctrl_t;

endpackage
`default_nettype wire

[sv/psam_pt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psam_pt_if: point input channel
// One 3D point per item, with a flag on the final point of a set.
// ----------------------------------------------------------------------------
interface psam_pt_if;
	logic             valid;
	logic             ready;
	psam_pkg::coord_t x_coord;
	psam_pkg::coord_t y_coord;
	psam_pkg::coord_t z_coord;
	logic             last_point;

	modport source (output valid, output x_coord, output y_coord, output z_coord,
		output last_point, input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord,
		input last_point, output ready);
endinterface
`default_nettype wire

[sv/psam_med_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psam_med_if: median result channel
// Per-axis medians, set size and overflow flag, one item per set.
// ----------------------------------------------------------------------------
interface psam_med_if;
	logic             valid;
	logic             ready;
	psam_pkg::coord_t median_x;
	psam_pkg::coord_t median_y;
	psam_pkg::coord_t median_z;
	psam_pkg::size_t  set_size;
	logic             overflowed;

	modport source (output valid, output median_x, output median_y, output median_z,
		output set_size, output overflowed, input ready);
	modport sink (input valid, input median_x, input median_y, input median_z,
		input set_size, input overflowed, output ready);
endinterface
`default_nettype wire

[sv/point_set_axis_median_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_set_axis_median_top: per-axis median of a set of 3D points
// A stored point holds the input while each axis memory moves the kept
//   values above it up, one entry per cycle; a full set drops the point and
//   sets the overflow flag. A final point then passes the read and capture
//   states, and the result item is valid once the result register is free.
//   A new point is taken only after every axis memory has finished its shift.
//   Reset clears count, flags and control; the point memories are not
//   cleared.
// ----------------------------------------------------------------------------
module point_set_axis_median_top #(
	parameter int unsigned MAX_POINTS = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	psam_pt_if.sink     points,
	psam_med_if.source  medians
);

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [2:0] {T_IDLE, T_INS, T_RD, T_CAP} top_state_t;

	top_state_t           state_q;
	logic [CW-1:0]        count_q;
	logic                 ovf_q;
	logic                 last_q;

	logic                 accept;
	logic                 room;
	logic                 free;
	logic                 load;
	logic [2:0]           busy;
	psam_pkg::coord_t     rd_x;
	psam_pkg::coord_t     rd_y;
	psam_pkg::coord_t     rd_z;
	psam_pkg::lane_ctrl_t ctrl;
	logic [CW-1:0]        half;
	logic [AW-1:0]        mid;
	logic [AW-1:0]        n;
	logic [31:0]          count_w;

	assign points.ready = (state_q == T_IDLE);
	assign accept       = points.valid && points.ready;
	assign room         = count_q < CW'(MAX_POINTS);
	assign n            = count_q[AW-1:0];
	assign half         = count_q >> 1;
	assign mid          = half[AW-1:0];
	assign count_w      = 32'(count_q);
	assign load         = (state_q == T_CAP) && free;

	assign ctrl.start  = accept && room;
	assign ctrl.rd_med = (state_q == T_RD) || (state_q == T_CAP);

	psam_lane #(.DEPTH(MAX_POINTS), .AW(AW)) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.n      (n),
		.v      (points.x_coord),
		.mid    (mid),
		.busy   (busy[0]),
		.rdata  (rd_x)
	);

	psam_lane #(.DEPTH(MAX_POINTS), .AW(AW)) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.n      (n),
		.v      (points.y_coord),
		.mid    (mid),
		.busy   (busy[1]),
		.rdata  (rd_y)
	);

	psam_lane #(.DEPTH(MAX_POINTS), .AW(AW)) u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.n      (n),
		.v      (points.z_coord),
		.mid    (mid),
		.busy   (busy[2]),
		.rdata  (rd_z)
	);

	psam_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.med_x   (rd_x),
		.med_y   (rd_y),
		.med_z   (rd_z),
		.size    (count_w[psam_pkg::SizeW-1:0]),
		.ovf     (ovf_q),
		.free    (free),
		.medians (medians)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						last_q <= points.last_point;
						if (room) begin
							count_q <= count_q + CW'(1);
							state_q <= T_INS;
						end else begin
							ovf_q <= 1'b1;
							if (points.last_point) begin
								state_q <= T_RD;
							end
						end
					end
				end
				T_INS: begin
					if (busy == '0) begin
						state_q <= last_q ? T_RD : T_IDLE;
					end
				end
				T_RD: begin
					state_q <= T_CAP;
				end
				T_CAP: begin
					if (free) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/psam_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psam_lane: sorted list for one axis
// Insert a value into a memory kept in ascending signed order, moving one
// larger entry up per cycle, and read the entry at a given position.
// ----------------------------------------------------------------------------
module psam_lane #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire psam_pkg::lane_ctrl_t ctrl,
	input  wire [AW-1:0]              n,
	input  wire psam_pkg::coord_t     v,
	input  wire [AW-1:0]              mid,
	output logic                      busy,
	output psam_pkg::coord_t          rdata
);

	typedef enum logic {L_IDLE, L_RUN} lane_state_t;

	lane_state_t      state_q;
	logic [AW-1:0]    p_q;
	psam_pkg::coord_t v_q;
	psam_pkg::coord_t rdata_q;
	psam_pkg::coord_t mem_q [DEPTH];

	logic             we;
	logic [AW-1:0]    wa;
	logic [AW-1:0]    ra;
	psam_pkg::coord_t wd;
	logic             shift;

	assign shift = (p_q != '0) && ($signed(v_q) < $signed(rdata_q));
	assign busy  = (state_q == L_RUN);
	assign rdata = rdata_q;

	always_comb begin
		we = 1'b0;
		wa = p_q;
		wd = v_q;
		ra = p_q - AW'(2);
		if (ctrl.start) begin
			ra = n - AW'(1);
			if (n == '0) begin
				we = 1'b1;
				wa = '0;
				wd = v;
			end
		end else if (ctrl.rd_med) begin
			ra = mid;
		end else if (state_q == L_RUN) begin
			we = 1'b1;
			if (shift) begin
				wd = rdata_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			p_q     <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (ctrl.start && n != '0) begin
						state_q <= L_RUN;
						p_q     <= n;
					end
				end
				L_RUN: begin
					if (shift) begin
						p_q <= p_q - AW'(1);
					end else begin
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			v_q <= v;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rdata_q <= mem_q[ra];
	end

endmodule
`default_nettype wire

[sv/psam_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psam_merge: result register
// Combine the three lane medians with count and overflow into one held item.
// ----------------------------------------------------------------------------
module psam_merge (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  wire psam_pkg::coord_t med_x,
	input  wire psam_pkg::coord_t med_y,
	input  wire psam_pkg::coord_t med_z,
	input  wire psam_pkg::size_t  size,
	input  wire                   ovf,
	output logic                  free,
	psam_med_if.source            medians
);

	logic             valid_q;
	psam_pkg::coord_t mx_q;
	psam_pkg::coord_t my_q;
	psam_pkg::coord_t mz_q;
	psam_pkg::size_t  size_q;
	logic             ovf_q;

	assign free = !valid_q || medians.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (medians.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mx_q   <= med_x;
			my_q   <= med_y;
			mz_q   <= med_z;
			size_q <= size;
			ovf_q  <= ovf;
		end
	end

	assign medians.valid      = valid_q;
	assign medians.median_x   = mx_q;
	assign medians.median_y   = my_q;
	assign medians.median_z   = mz_q;
	assign medians.set_size   = size_q;
	assign medians.overflowed = ovf_q;

endmodule
`default_nettype wire
